@@ rtl/gbte_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbte_pkg
// Shared types and codes for the gap buffer text editor: command kinds,
// status codes and the per-cycle shift operation of a cell chain.
// ----------------------------------------------------------------------------
package gbte_pkg;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_POP
  } shift_op_e;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DEL    = 3'd1;
  localparam logic [2:0] KIND_RUN    = 3'd2;
  localparam logic [2:0] KIND_FWD    = 3'd3;
  localparam logic [2:0] KIND_BWD    = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

endpackage
`default_nettype wire

@@ rtl/gap_buffer_text_editor.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gap_buffer_text_editor
// Byte text editor with a cursor, held as two cell chains around the gap.
// ----------------------------------------------------------------------------
// The text before the cursor sits in one chain of cells (top = byte before
// the cursor), the text after it in a second chain (top = byte at the
// cursor); the gap is the space between them. A command is taken when start
// is high and busy is low. Insert, delete before, read, unused kinds,
// refused commands and moves or runs of zero give their result on done_o in
// the cycle after the transfer, and the next command may be taken in that same cycle.
// Delete run, forward and backward move n bytes through the chains at one
// byte per cycle with busy high, where n is the run length or the clamped
// step. done_o is high for exactly one cycle and cannot be stalled; the
// receiver must take it then.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       kind_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [10:0]      count_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [7:0]            read_byte_o,
  output logic [CNT_W-1:0]      cursor_offset_o,
  output logic [CNT_W-1:0]      text_length_o
);

  localparam int unsigned CMP_W = (CNT_W > 11) ? CNT_W : 11;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SHIFT = 1'b1;

  localparam logic [1:0] MODE_DEL = 2'd0;
  localparam logic [1:0] MODE_FWD = 2'd1;
  localparam logic [1:0] MODE_BWD = 2'd2;

  logic             state_q, state_d;
  logic [1:0]       mode_q, mode_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic [CNT_W-1:0] left_len_q, left_len_d;
  logic [CNT_W-1:0] right_len_q, right_len_d;
  logic             done_q, done_d;
  logic [1:0]       status_q, status_d;
  logic [7:0]       rd_q, rd_d;

  gbte_pkg::shift_op_e left_op, right_op;
  logic [7:0]          left_push, right_push, left_top, right_top;

  logic [CMP_W-1:0] count_ext, left_ext, right_ext;
  logic [CNT_W-1:0] fwd_n, bwd_n;
  logic             full;

  assign count_ext = CMP_W'(count_i);
  assign left_ext  = CMP_W'(left_len_q);
  assign right_ext = CMP_W'(right_len_q);
  assign fwd_n     = (count_ext >= right_ext) ? right_len_q : count_ext[CNT_W-1:0];
  assign bwd_n     = (count_ext >= left_ext) ? left_len_q : count_ext[CNT_W-1:0];
  assign full      = (CNT_W'(left_len_q + right_len_q) == CNT_W'(CAPACITY));

  gbte_stack #(.DEPTH(CAPACITY)) u_left (
    .clk_i       (clk_i),
    .op_i        (left_op),
    .push_byte_i (left_push),
    .top_byte_o  (left_top)
  );

  gbte_stack #(.DEPTH(CAPACITY)) u_right (
    .clk_i       (clk_i),
    .op_i        (right_op),
    .push_byte_i (right_push),
    .top_byte_o  (right_top)
  );

  always_comb begin
    left_op     = gbte_pkg::SH_HOLD;
    right_op    = gbte_pkg::SH_HOLD;
    left_push   = data_byte_i;
    right_push  = left_top;
    state_d     = state_q;
    mode_d      = mode_q;
    steps_d     = steps_q;
    left_len_d  = left_len_q;
    right_len_d = right_len_q;
    done_d      = 1'b0;
    status_d    = status_q;
    rd_d        = rd_q;
    if (state_q == ST_IDLE) begin
      if (start) begin
        status_d = gbte_pkg::STAT_OK;
        rd_d     = 8'h00;
        done_d   = 1'b1;
        unique case (kind_i)
          gbte_pkg::KIND_INSERT: begin
            if (full) begin
              status_d = gbte_pkg::STAT_FULL;
            end else begin
              left_op    = gbte_pkg::SH_PUSH;
              left_len_d = left_len_q + 1'b1;
            end
          end
          gbte_pkg::KIND_DEL: begin
            if (left_len_q == '0) begin
              status_d = gbte_pkg::STAT_RANGE;
            end else begin
              left_op    = gbte_pkg::SH_POP;
              left_len_d = left_len_q - 1'b1;
            end
          end
          gbte_pkg::KIND_RUN: begin
            if (count_ext > left_ext) begin
              status_d = gbte_pkg::STAT_RANGE;
            end else if (count_i != '0) begin
              done_d  = 1'b0;
              state_d = ST_SHIFT;
              mode_d  = MODE_DEL;
              steps_d = count_ext[CNT_W-1:0];
            end
          end
          gbte_pkg::KIND_FWD: begin
            if (fwd_n != '0) begin
              done_d  = 1'b0;
              state_d = ST_SHIFT;
              mode_d  = MODE_FWD;
              steps_d = fwd_n;
            end
          end
          gbte_pkg::KIND_BWD: begin
            if (bwd_n != '0) begin
              done_d  = 1'b0;
              state_d = ST_SHIFT;
              mode_d  = MODE_BWD;
              steps_d = bwd_n;
            end
          end
          gbte_pkg::KIND_READ: begin
            if (right_len_q == '0) begin
              status_d = gbte_pkg::STAT_RANGE;
            end else begin
              rd_d = right_top;
            end
          end
          default: begin
            status_d = gbte_pkg::STAT_RANGE;
          end
        endcase
      end
    end else begin
      unique case (mode_q)
        MODE_DEL: begin
          left_op    = gbte_pkg::SH_POP;
          left_len_d = left_len_q - 1'b1;
        end
        MODE_FWD: begin
          left_op     = gbte_pkg::SH_PUSH;
          left_push   = right_top;
          right_op    = gbte_pkg::SH_POP;
          left_len_d  = left_len_q + 1'b1;
          right_len_d = right_len_q - 1'b1;
        end
        MODE_BWD: begin
          right_op    = gbte_pkg::SH_PUSH;
          right_push  = left_top;
          left_op     = gbte_pkg::SH_POP;
          left_len_d  = left_len_q - 1'b1;
          right_len_d = right_len_q + 1'b1;
        end
        default: begin
          left_op = gbte_pkg::SH_HOLD;
        end
      endcase
      steps_d = steps_q - 1'b1;
      if (steps_q == CNT_W'(1)) begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_DEL;
      steps_q     <= '0;
      left_len_q  <= '0;
      right_len_q <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      steps_q     <= steps_d;
      left_len_q  <= left_len_d;
      right_len_q <= right_len_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rd_q     <= rd_d;
  end

  assign busy            = (state_q == ST_SHIFT);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign read_byte_o     = rd_q;
  assign cursor_offset_o = left_len_q;
  assign text_length_o   = CNT_W'(left_len_q + right_len_q);

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CMP_W + 1)'(left_len_q) + (CMP_W + 1)'(right_len_q) <= (CMP_W + 1)'(CAPACITY))
    else $error("text exceeds capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while busy");

  a_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("shift ended without result");

  a_insert_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i == gbte_pkg::KIND_INSERT && !full) |=>
      (text_length_o == CNT_W'($past(text_length_o) + 1'b1)))
    else $error("insert did not grow text");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && steps_q != CNT_W'(1)) |=>
      (busy && steps_q == CNT_W'($past(steps_q) - 1'b1)))
    else $error("shift step count slipped");
`endif

endmodule
`default_nettype wire

@@ rtl/gbte_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbte_cell
// One byte of a stack chain. Push takes the byte from the neighbor nearer
// the top, pop takes the byte from the neighbor further down, else holds.
// ----------------------------------------------------------------------------
module gbte_cell (
  input  wire logic                clk_i,
  input  wire gbte_pkg::shift_op_e op_i,
  input  wire logic [7:0]          up_i,
  input  wire logic [7:0]          dn_i,
  output logic [7:0]               q_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    case (op_i)
      gbte_pkg::SH_PUSH: byte_d = up_i;
      gbte_pkg::SH_POP:  byte_d = dn_i;
      default:           byte_d = byte_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o = byte_q;

endmodule
`default_nettype wire

@@ rtl/gbte_stack.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gbte_stack
// A row of byte cells forming a stack. Cell 0 is the top; every cell shifts
// in lockstep, one position per cycle while op_i is push or pop.
// ----------------------------------------------------------------------------
module gbte_stack #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                clk_i,
  input  wire gbte_pkg::shift_op_e op_i,
  input  wire logic [7:0]          push_byte_i,
  output logic [7:0]               top_byte_o
);

  logic [7:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [7:0] up, dn;
    if (i == 0) begin : g_first
      assign up = push_byte_i;
    end else begin : g_mid_up
      assign up = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign dn = 8'h00;
    end else begin : g_mid_dn
      assign dn = cell_q[i+1];
    end
    gbte_cell u_cell (
      .clk_i (clk_i),
      .op_i  (op_i),
      .up_i  (up),
      .dn_i  (dn),
      .q_o   (cell_q[i])
    );
  end

  assign top_byte_o = cell_q[0];

endmodule
`default_nettype wire

@@ bench/gap_buffer_text_editor_checker.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_text_editor_checker
// Watches the command and result channels of the gap buffer editor. It keeps
// its own copy of the text and the cursor and works out the result that each
// accepted command must give. It compares every result field by field, in
// order, and counts the failures.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor_checker #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [2:0]       kind_i,
  input  logic [7:0]       data_byte_i,
  input  logic [10:0]      count_i,
  input  logic             done_i,
  input  logic [1:0]       status_i,
  input  logic [7:0]       read_byte_i,
  input  logic [CNT_W-1:0] cursor_offset_i,
  input  logic [CNT_W-1:0] text_length_i,
  output int               pending_o,
  output int               fail_count_o
);

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       read_byte;
    logic [CNT_W-1:0] cursor;
    logic [CNT_W-1:0] length;
  } edit_result_t;

  logic [7:0]   text_bytes[$];
  int unsigned  cursor_pos = 0;
  edit_result_t pending_results[$];
  int           errs = 0;

  function automatic edit_result_t edit_outcome(input logic [2:0] kind,
                                                input logic [7:0] data,
                                                input logic [10:0] count);
    edit_result_t res;
    int unsigned  len;
    res           = '0;
    res.status    = gbte_pkg::STAT_OK;
    len           = text_bytes.size();
    case (kind)
      gbte_pkg::KIND_INSERT: begin
        if (len >= CAPACITY) begin
          res.status = gbte_pkg::STAT_FULL;
        end else begin
          text_bytes.insert(cursor_pos, data);
          cursor_pos++;
        end
      end
      gbte_pkg::KIND_DEL: begin
        if (cursor_pos == 0) begin
          res.status = gbte_pkg::STAT_RANGE;
        end else begin
          text_bytes.delete(cursor_pos - 1);
          cursor_pos--;
        end
      end
      gbte_pkg::KIND_RUN: begin
        if (count > cursor_pos) begin
          res.status = gbte_pkg::STAT_RANGE;
        end else begin
          repeat (count) begin
            text_bytes.delete(cursor_pos - 1);
            cursor_pos--;
          end
        end
      end
      gbte_pkg::KIND_FWD: begin
        cursor_pos = (count >= len - cursor_pos) ? len : cursor_pos + count;
      end
      gbte_pkg::KIND_BWD: begin
        cursor_pos = (count >= cursor_pos) ? 0 : cursor_pos - count;
      end
      gbte_pkg::KIND_READ: begin
        if (cursor_pos >= len) begin
          res.status = gbte_pkg::STAT_RANGE;
        end else begin
          res.read_byte = text_bytes[cursor_pos];
        end
      end
      default: begin
        res.status = gbte_pkg::STAT_RANGE;
      end
    endcase
    res.cursor = CNT_W'(cursor_pos);
    res.length = CNT_W'(text_bytes.size());
    return res;
  endfunction

  function automatic void check_field(input string field, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errs++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    edit_result_t want;
    if (rst_ni) begin
      if (done_i) begin
        if (pending_results.size() == 0) begin
          errs++;
          $display("%0t: unexpected result: expected none, got status %0d byte %0d",
                   $time, status_i, read_byte_i);
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("read_byte", want.read_byte, read_byte_i);
          check_field("cursor_offset", want.cursor, cursor_offset_i);
          check_field("text_length", want.length, text_length_i);
        end
      end
      if (start_i && !busy_i) begin
        pending_results.push_back(edit_outcome(kind_i, data_byte_i, count_i));
      end
    end
    pending_o    <= pending_results.size();
    fail_count_o <= errs;
  end

endmodule

@@ bench/gap_buffer_text_editor_tb.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_text_editor_tb
// Drives edit commands into the gap buffer editor: a directed opening over
// the refused and clamped cases, then random editing with a fill of the
// whole store, a full delete run and a mix of moves and reads, under varying
// sender gaps. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor_tb;

  localparam int unsigned CAP         = 1024;
  localparam int unsigned CNT_W       = $clog2(CAP + 1);
  localparam int          STALL_LIMIT = 5000;
  localparam logic [2:0]  KIND_SPARE_LO = 3'd6;
  localparam logic [2:0]  KIND_SPARE_HI = 3'd7;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  logic [2:0]       kind      = '0;
  logic [7:0]       data_byte = '0;
  logic [10:0]      count     = '0;
  logic             done;
  logic [1:0]       status;
  logic [7:0]       read_byte;
  logic [CNT_W-1:0] cursor_offset;
  logic [CNT_W-1:0] text_length;
  int               pending;
  int               fail_count;

  int               idle_pct      = 0;
  int               shadow_len    = 0;
  int               shadow_cursor = 0;
  int               stall_cycles  = 0;

  gap_buffer_text_editor #(.CAPACITY(CAP)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind),
    .data_byte_i     (data_byte),
    .count_i         (count),
    .done_o          (done),
    .status_o        (status),
    .read_byte_o     (read_byte),
    .cursor_offset_o (cursor_offset),
    .text_length_o   (text_length)
  );

  gap_buffer_text_editor_checker #(.CAPACITY(CAP)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .kind_i          (kind),
    .data_byte_i     (data_byte),
    .count_i         (count),
    .done_i          (done),
    .status_i        (status),
    .read_byte_i     (read_byte),
    .cursor_offset_i (cursor_offset),
    .text_length_i   (text_length),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("gap_buffer_text_editor_tb failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // coarse text length and cursor, only to steer the stimulus
  function automatic void track(input logic [2:0] k, input int n);
    case (k)
      gbte_pkg::KIND_INSERT: begin
        if (shadow_len < CAP) begin
          shadow_len++;
          shadow_cursor++;
        end
      end
      gbte_pkg::KIND_DEL: begin
        if (shadow_cursor > 0) begin
          shadow_len--;
          shadow_cursor--;
        end
      end
      gbte_pkg::KIND_RUN: begin
        if (n <= shadow_cursor) begin
          shadow_len    -= n;
          shadow_cursor -= n;
        end
      end
      gbte_pkg::KIND_FWD: begin
        shadow_cursor = (n >= shadow_len - shadow_cursor) ? shadow_len : shadow_cursor + n;
      end
      gbte_pkg::KIND_BWD: begin
        shadow_cursor = (n >= shadow_cursor) ? 0 : shadow_cursor - n;
      end
      default: begin
      end
    endcase
  endfunction

  task automatic issue(input logic [2:0] k, input logic [7:0] b, input logic [10:0] n);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    kind      <= k;
    data_byte <= b;
    count     <= n;
    track(k, n);
    do @(posedge clk); while (busy);
  endtask

  function automatic int pace_for(input int i);
    case ((i / 50) % 3)
      0:       return 0;
      1:       return 67;
      default: return 15;
    endcase
  endfunction

  task automatic random_edit(input int ins_pct);
    int          r;
    int          run_max;
    logic [10:0] n;
    logic [7:0]  b;
    b = 8'($urandom_range(0, 255));
    n = ($urandom_range(0, 19) == 0) ? 11'($urandom_range(0, 2047))
                                     : 11'($urandom_range(0, 4));
    r = $urandom_range(0, 99);
    if (r < ins_pct) begin
      issue(gbte_pkg::KIND_INSERT, b, n);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        issue(gbte_pkg::KIND_DEL, b, n);
      end else if (r < 45) begin
        run_max = (shadow_cursor < 6) ? shadow_cursor + 1 : 7;
        if ($urandom_range(0, 9) != 0) n = 11'($urandom_range(0, run_max));
        issue(gbte_pkg::KIND_RUN, b, n);
      end else if (r < 62) begin
        issue(gbte_pkg::KIND_FWD, b, n);
      end else if (r < 79) begin
        issue(gbte_pkg::KIND_BWD, b, n);
      end else if (r < 96) begin
        issue(gbte_pkg::KIND_READ, b, n);
      end else begin
        issue($urandom_range(0, 1) ? KIND_SPARE_LO : KIND_SPARE_HI, b, n);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // from empty: refused deletes and runs, reads, clamped moves, spare kinds
    issue(gbte_pkg::KIND_DEL, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_RUN, 8'h00, 11'd1);
    issue(gbte_pkg::KIND_RUN, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_READ, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_BWD, 8'h00, 11'd5);
    issue(gbte_pkg::KIND_FWD, 8'h00, 11'd5);
    issue(gbte_pkg::KIND_INSERT, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_INSERT, 8'hFF, 11'd2047);
    issue(gbte_pkg::KIND_INSERT, 8'hA5, 11'd0);
    issue(gbte_pkg::KIND_BWD, 8'h00, 11'd2);
    issue(gbte_pkg::KIND_READ, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_INSERT, 8'h5A, 11'd0);
    issue(gbte_pkg::KIND_FWD, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_FWD, 8'h00, 11'd2047);
    issue(gbte_pkg::KIND_BWD, 8'h00, 11'd1024);
    issue(gbte_pkg::KIND_READ, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_FWD, 8'h00, 11'd1);
    issue(gbte_pkg::KIND_DEL, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_FWD, 8'h00, 11'd2);
    issue(gbte_pkg::KIND_RUN, 8'h00, 11'd3);
    issue(gbte_pkg::KIND_RUN, 8'h00, 11'd2);
    issue(KIND_SPARE_LO, 8'hFF, 11'd2047);
    issue(KIND_SPARE_HI, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_READ, 8'hFF, 11'd2047);

    for (int i = 0; i < 70; i++) begin
      idle_pct = pace_for(i);
      random_edit(45);
    end

    // grow the text until the store is full, then edit around the limit
    for (int i = 0; shadow_len < CAP; i++) begin
      idle_pct = pace_for(i);
      random_edit(92);
    end
    for (int i = 0; i < 30; i++) begin
      idle_pct = pace_for(i + 100);
      random_edit(70);
    end
    while (shadow_len < CAP) begin
      issue(gbte_pkg::KIND_INSERT, 8'($urandom_range(0, 255)), 11'd0);
    end
    issue(gbte_pkg::KIND_INSERT, 8'hFF, 11'd0);
    issue(gbte_pkg::KIND_FWD, 8'h00, 11'd2047);
    issue(gbte_pkg::KIND_READ, 8'h00, 11'd0);
    issue(gbte_pkg::KIND_RUN, 8'h00, 11'(shadow_cursor));

    for (int i = 0; i < 40; i++) begin
      idle_pct = pace_for(i + 50);
      random_edit(40);
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("gap_buffer_text_editor_tb passed");
    end else begin
      $display("gap_buffer_text_editor_tb failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/gbte_pkg.sv
rtl/gbte_cell.sv
rtl/gbte_stack.sv
rtl/gap_buffer_text_editor.sv
bench/gap_buffer_text_editor_checker.sv
bench/gap_buffer_text_editor_tb.sv
